// ===== rtl/aaf_pkg.sv =====
// ----------------------------------------------------------------------------
// aaf_pkg: shared types and constants
// Command codes, flag bit positions and the ALU result bundle.
// ----------------------------------------------------------------------------
package aaf_pkg;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_LOAD    = 5'd0;
  localparam cmd_t CMD_ADD     = 5'd1;
  localparam cmd_t CMD_ADC     = 5'd2;
  localparam cmd_t CMD_SUB     = 5'd3;
  localparam cmd_t CMD_SBC     = 5'd4;
  localparam cmd_t CMD_AND     = 5'd5;
  localparam cmd_t CMD_XOR     = 5'd6;
  localparam cmd_t CMD_OR      = 5'd7;
  localparam cmd_t CMD_RLC     = 5'd8;
  localparam cmd_t CMD_RRC     = 5'd9;
  localparam cmd_t CMD_RL      = 5'd10;
  localparam cmd_t CMD_RR      = 5'd11;
  localparam cmd_t CMD_SLA     = 5'd12;
  localparam cmd_t CMD_SRA     = 5'd13;
  localparam cmd_t CMD_SRL     = 5'd14;
  localparam cmd_t CMD_SETBIT  = 5'd15;
  localparam cmd_t CMD_RESBIT  = 5'd16;
  localparam cmd_t CMD_READ    = 5'd17;
  localparam cmd_t CMD_ADDPEEK = 5'd18;
  localparam cmd_t CMD_SUBPEEK = 5'd19;

  // Flag byte bit positions
  localparam int FLAG_Z_BIT = 7;
  localparam int FLAG_N_BIT = 6;
  localparam int FLAG_H_BIT = 5;
  localparam int FLAG_C_BIT = 4;

  // One decoded request
  typedef struct packed {
    cmd_t       command;
    logic [7:0] operand;
    logic       carry_bit;
    logic [2:0] bit_index;
  } aaf_req_t;

  // ALU outcome for one request
  typedef struct packed {
    logic [7:0] acc_next;
    logic [7:0] value;
    logic [7:0] flags;
    logic       bit_out;
    logic       peek;
  } aaf_res_t;

endpackage

// ===== rtl/accumulator_alu_with_flags_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_top: 8-bit accumulator with flag-reporting ALU
// Input request register, ALU, accumulator and output result register.
// ----------------------------------------------------------------------------
// Each request carries a command, operand, carry-in and bit index and yields
// one result: value, flag byte (Z N H C in bits 7..4) and the indexed bit.
// The block takes one request per cycle unless m_tready holds the result
// register; a request passes through the request register into the result
// register, which drives m_tvalid/m_tdata. The ALU path is combinational;
// the accumulator is updated as a request moves into the result register, so
// the next request always sees the value the previous one left. The result
// register lets a new request be taken while a finished result still waits
// for m_tready. Reset clears the accumulator to zero.
module accumulator_alu_with_flags_top
  import aaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // command[4:0], operand[12:5], carry_bit[13],
                                 // bit_index[16:14], zero[23:17]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // value[7:0], flags[15:8], bit_out[16], zero[23:17]
);

  logic       req_valid;
  aaf_req_t   req;
  logic [7:0] acc;
  aaf_res_t   res;
  logic       advance;
  logic [7:0] out_value;
  logic [7:0] out_flags;
  logic       out_bit;
  logic       out_peek;

  // Pipeline control
  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req.command   <= s_tdata[4:0];
      req.operand   <= s_tdata[12:5];
      req.carry_bit <= s_tdata[13];
      req.bit_index <= s_tdata[16:14];
    end
  end

  // ALU
  aaf_alu u_alu (
    .acc (acc),
    .req (req),
    .res (res)
  );

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
    end else if (advance) begin
      acc <= res.acc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= res.value;
      out_flags <= res.flags;
      out_bit   <= res.bit_out;
      out_peek  <= res.peek;
    end
  end

  assign m_tdata = {7'd0, out_bit, out_flags, out_value};

  // Checks
  property p_flags_low_zero;
    @(posedge clk) disable iff (rst) m_tvalid |-> (out_flags[3:0] == 4'd0);
  endproperty
  a_flags_low_zero: assert property (p_flags_low_zero)
    else $error("flag low nibble not zero");

  property p_value_is_acc;
    @(posedge clk) disable iff (rst) (m_tvalid && !out_peek) |-> (out_value == acc);
  endproperty
  a_value_is_acc: assert property (p_value_is_acc)
    else $error("shown value differs from accumulator");

  property p_bit_matches_acc;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !out_peek && (out_value == 8'd0)) |-> !out_bit;
  endproperty
  a_bit_matches_acc: assert property (p_bit_matches_acc)
    else $error("indexed bit set on zero accumulator");

  property p_reset_empty;
    @(posedge clk) $past(rst) |-> (!m_tvalid && !req_valid);
  endproperty
  a_reset_empty: assert property (p_reset_empty)
    else $error("pipeline not empty after reset");

endmodule

// ===== rtl/aaf_alu.sv =====
// ----------------------------------------------------------------------------
// aaf_alu: accumulator ALU datapath
// Computes the new accumulator, shown value, flag byte and indexed bit
// for one request from the current accumulator. Purely combinational.
// ----------------------------------------------------------------------------
module aaf_alu
  import aaf_pkg::*;
(
  input  logic [7:0] acc,
  input  aaf_req_t   req,
  output aaf_res_t   res
);

  logic       ci;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] diff9;
  logic [4:0] diff_lo;
  logic [7:0] r;
  logic [7:0] shown;
  logic       f_z;
  logic       f_n;
  logic       f_h;
  logic       f_c;
  logic       f_en;

  // Carry/borrow only for the with-carry forms
  assign ci = ((req.command == CMD_ADC) || (req.command == CMD_SBC)) ? req.carry_bit : 1'b0;

  // Shared adder and subtractor with nibble carry/borrow
  assign sum9    = {1'b0, acc} + {1'b0, req.operand} + {8'd0, ci};
  assign sum_lo  = {1'b0, acc[3:0]} + {1'b0, req.operand[3:0]} + {4'd0, ci};
  assign diff9   = {1'b0, acc} - {1'b0, req.operand} - {8'd0, ci};
  assign diff_lo = {1'b0, acc[3:0]} - {1'b0, req.operand[3:0]} - {4'd0, ci};

  // Operation select
  always_comb begin
    r     = acc;
    f_n   = 1'b0;
    f_h   = 1'b0;
    f_c   = 1'b0;
    f_en  = 1'b1;
    case (req.command)
      CMD_LOAD: begin
        r    = req.operand;
        f_en = 1'b0;
      end
      CMD_ADD, CMD_ADC: begin
        r   = sum9[7:0];
        f_h = sum_lo[4];
        f_c = sum9[8];
      end
      CMD_SUB, CMD_SBC: begin
        r   = diff9[7:0];
        f_n = 1'b1;
        f_h = diff_lo[4];
        f_c = diff9[8];
      end
      CMD_AND: r = acc & req.operand;
      CMD_XOR: r = acc ^ req.operand;
      CMD_OR:  r = acc | req.operand;
      CMD_RLC: begin
        r   = {acc[6:0], acc[7]};
        f_c = acc[7];
      end
      CMD_RRC: begin
        r   = {acc[0], acc[7:1]};
        f_c = acc[0];
      end
      CMD_RL: begin
        r   = {acc[6:0], req.carry_bit};
        f_c = acc[7];
      end
      CMD_RR: begin
        r   = {req.carry_bit, acc[7:1]};
        f_c = acc[0];
      end
      CMD_SLA: begin
        r   = {acc[6:0], 1'b0};
        f_c = acc[7];
      end
      CMD_SRA: begin
        r   = {acc[7], acc[7:1]};
        f_c = acc[0];
      end
      CMD_SRL: begin
        r   = {1'b0, acc[7:1]};
        f_c = acc[0];
      end
      CMD_SETBIT: begin
        r    = acc | (8'd1 << req.bit_index);
        f_en = 1'b0;
      end
      CMD_RESBIT: begin
        r    = acc & ~(8'd1 << req.bit_index);
        f_en = 1'b0;
      end
      default: f_en = 1'b0;  // read, peeks and unused codes
    endcase
  end

  // Peeks show the sum/difference but keep the accumulator
  always_comb begin
    case (req.command)
      CMD_ADDPEEK: shown = sum9[7:0];
      CMD_SUBPEEK: shown = diff9[7:0];
      default:     shown = r;
    endcase
  end

  assign f_z = (r == 8'd0);

  always_comb begin
    res.acc_next = r;
    res.value    = shown;
    res.flags    = 8'd0;
    if (f_en) begin
      res.flags[FLAG_Z_BIT] = f_z;
      res.flags[FLAG_N_BIT] = f_n;
      res.flags[FLAG_H_BIT] = f_h;
      res.flags[FLAG_C_BIT] = f_c;
    end
    res.bit_out = r[req.bit_index];
    res.peek    = (req.command == CMD_ADDPEEK) || (req.command == CMD_SUBPEEK);
  end

endmodule
